/* rtl/fds_pkg.sv */
`default_nettype none

package fds_pkg;

  localparam int unsigned MaxFacesDef = 16;
  localparam int unsigned IdW         = 4;
  localparam int unsigned KeyW        = 24;
  localparam int unsigned OrdHiW      = KeyW + 1;

  localparam logic FigBox     = 1'b0;
  localparam logic FigPyramid = 1'b1;

  typedef struct packed {
    logic [IdW-1:0]         face_id;
    logic                   figure;
    logic                   shadowed;
    logic signed [KeyW-1:0] key;
  } entry_t;

  function automatic logic signed [KeyW-1:0] max_z(
    input logic signed [KeyW-1:0] a,
    input logic signed [KeyW-1:0] b
  );
    return (b > a) ? b : a;
  endfunction

  function automatic logic signed [KeyW-1:0] face_key(
    input logic                   fig,
    input logic signed [KeyW-1:0] z0,
    input logic signed [KeyW-1:0] z1,
    input logic signed [KeyW-1:0] z2,
    input logic signed [KeyW-1:0] z3
  );
    logic signed [KeyW-1:0] m;
    m = max_z(max_z(z0, z1), z2);
    if (fig == FigBox) begin
      m = max_z(m, z3);
    end
    return m;
  endfunction

  // Upper part of the emit order: ascending key, pyramid before box on a tie.
  function automatic logic [OrdHiW-1:0] ord_hi(input entry_t e);
    return {~e.key[KeyW-1], e.key[KeyW-2:0], ~e.figure};
  endfunction

endpackage

`default_nettype wire

/* rtl/fds_store.sv */
`default_nettype none

module fds_store
  import fds_pkg::*;
#(
  parameter int unsigned Depth = MaxFacesDef,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/fds_sel.sv */
`default_nettype none

module fds_sel
  import fds_pkg::*;
#(
  parameter int unsigned MaxFaces = MaxFacesDef,
  localparam int unsigned IdxW = $clog2(MaxFaces)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clr_i,
  input  logic            cand_vld_i,
  input  logic [IdxW-1:0] cand_idx_i,
  input  entry_t          cand_i,
  output entry_t          best_o,
  output logic [IdxW-1:0] best_idx_o
);

  logic                       best_vld_q, best_vld_d;
  entry_t                     best_q, best_d;
  logic [IdxW-1:0]            best_idx_q, best_idx_d;
  logic [OrdHiW+IdxW-1:0]     cand_ord, best_ord;
  logic                       take;

  // Later arrivals go first on a full tie.
  assign cand_ord = {ord_hi(cand_i), ~cand_idx_i};
  assign best_ord = {ord_hi(best_q), ~best_idx_q};
  assign take     = cand_vld_i && (!best_vld_q || (cand_ord < best_ord));

  always_comb begin
    best_vld_d = best_vld_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    if (clr_i) begin
      best_vld_d = 1'b0;
    end else if (take) begin
      best_vld_d = 1'b1;
      best_d     = cand_i;
      best_idx_d = cand_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_vld_q <= 1'b0;
      best_q     <= '0;
      best_idx_q <= '0;
    end else begin
      best_vld_q <= best_vld_d;
      best_q     <= best_d;
      best_idx_q <= best_idx_d;
    end
  end

  assign best_o     = best_q;
  assign best_idx_o = best_idx_q;

endmodule

`default_nettype wire

/* rtl/face_depth_sorter.sv */
`default_nettype none

// Painter's-order depth sorter. Faces stream in one per cycle; each is stored
// with its key, the largest of its vertex depths (three for a pyramid face,
// four for a box face). The face flagged with tlast closes the batch: the
// stored faces then leave in ascending key order, pyramid before box on equal
// keys and later arrivals first within a figure, with tlast on the final one.
// Faces beyond MaxFaces are dropped. Each result comes from one full pass of
// the shared comparator over the store (one store read port, one compare per
// cycle); no input is taken while a batch drains.
module face_depth_sorter
  import fds_pkg::*;
#(
  parameter int unsigned MaxFaces = MaxFacesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // face_id[3:0], shadowed[4], vertex_z0[28:5], vertex_z1[52:29],
  // vertex_z2[76:53], vertex_z3[100:77], zero[103:101]
  input  logic [103:0] s_axis_tdata_i,
  // figure
  input  logic         s_axis_tuser_i,
  input  logic         s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // out_face_id[3:0], out_shadowed[4], depth_key[28:5], zero[31:29]
  output logic [31:0]  m_axis_tdata_o,
  // out_figure
  output logic         m_axis_tuser_o,
  output logic         m_axis_tlast_o
);

  localparam int unsigned IdxW = $clog2(MaxFaces);
  localparam int unsigned CntW = $clog2(MaxFaces + 1);

  typedef enum logic [1:0] {StLoad, StScan, StPick, StEmit} state_e;

  state_e               state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      scan_q, scan_d;
  logic [CntW-1:0]      emit_cnt_q, emit_cnt_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]      rd_idx_q, rd_idx_d;
  logic [MaxFaces-1:0]  done_q, done_d;
  entry_t               out_q, out_d;
  logic                 out_last_q, out_last_d;

  logic                 in_acc, out_acc, has_room, issuing, start_scan;
  entry_t               wr_entry, rd_entry, best;
  logic [IdxW-1:0]      best_idx;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc  = m_axis_tvalid_o && m_axis_tready_i;
  assign has_room = count_q < CntW'(MaxFaces);
  assign issuing  = (state_q == StScan) && (scan_q < count_q);

  assign wr_entry.face_id  = s_axis_tdata_i[3:0];
  assign wr_entry.figure   = s_axis_tuser_i;
  assign wr_entry.shadowed = s_axis_tdata_i[4];
  assign wr_entry.key      = face_key(s_axis_tuser_i,
                                      $signed(s_axis_tdata_i[28:5]),
                                      $signed(s_axis_tdata_i[52:29]),
                                      $signed(s_axis_tdata_i[76:53]),
                                      $signed(s_axis_tdata_i[100:77]));

  fds_store #(
    .Depth   (MaxFaces)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && has_room),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (wr_entry),
    .raddr_i (scan_q[IdxW-1:0]),
    .rdata_o (rd_entry)
  );

  fds_sel #(
    .MaxFaces   (MaxFaces)
  ) u_sel (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (start_scan),
    .cand_vld_i (rd_vld_q && !done_q[rd_idx_q]),
    .cand_idx_i (rd_idx_q),
    .cand_i     (rd_entry),
    .best_o     (best),
    .best_idx_o (best_idx)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    scan_d     = scan_q;
    emit_cnt_d = emit_cnt_q;
    done_d     = done_q;
    out_d      = out_q;
    out_last_d = out_last_q;
    start_scan = 1'b0;
    rd_vld_d   = issuing;
    rd_idx_d   = scan_q[IdxW-1:0];
    unique case (state_q)
      StLoad: begin
        if (in_acc) begin
          if (has_room) begin
            count_d = CntW'(count_q + 1'b1);
          end
          if (s_axis_tlast_i) begin
            state_d    = StScan;
            scan_d     = '0;
            emit_cnt_d = '0;
            done_d     = '0;
            start_scan = 1'b1;
          end
        end
      end
      StScan: begin
        if (issuing) begin
          scan_d = CntW'(scan_q + 1'b1);
        end
        if (rd_vld_q && (scan_q == count_q)) begin
          state_d = StPick;
        end
      end
      StPick: begin
        out_d              = best;
        out_last_d         = (CntW'(emit_cnt_q + 1'b1) == count_q);
        done_d[best_idx]   = 1'b1;
        state_d            = StEmit;
      end
      StEmit: begin
        if (out_acc) begin
          if (out_last_q) begin
            state_d = StLoad;
            count_d = '0;
          end else begin
            state_d    = StScan;
            scan_d     = '0;
            emit_cnt_d = CntW'(emit_cnt_q + 1'b1);
            start_scan = 1'b1;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      count_q    <= '0;
      scan_q     <= '0;
      emit_cnt_q <= '0;
      rd_vld_q   <= 1'b0;
      rd_idx_q   <= '0;
      done_q     <= '0;
      out_q      <= '0;
      out_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      scan_q     <= scan_d;
      emit_cnt_q <= emit_cnt_d;
      rd_vld_q   <= rd_vld_d;
      rd_idx_q   <= rd_idx_d;
      done_q     <= done_d;
      out_q      <= out_d;
      out_last_q <= out_last_d;
    end
  end

  assign s_axis_tready_o = (state_q == StLoad);
  assign m_axis_tvalid_o = (state_q == StEmit);
  assign m_axis_tdata_o  = {3'b000, out_q.key, out_q.shadowed, out_q.face_id};
  assign m_axis_tuser_o  = out_q.figure;
  assign m_axis_tlast_o  = out_last_q;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input taken while a result is pending");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxFaces))
    else $error("face count beyond store depth");

  a_empty_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && m_axis_tlast_o) |=> (count_q == '0) && s_axis_tready_o)
    else $error("store not emptied after sorted run");

  a_done_tracks_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> ($countones(done_q) == emit_cnt_q + 1))
    else $error("emitted face marks out of step with emit count");

endmodule

`default_nettype wire

/* tb/face_depth_sorter_test.sv */
`timescale 1ns / 100ps

module face_depth_sorter_test;
  import fds_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned DrainCycles   = 400;
  localparam int unsigned FaceTarget    = 260;

  localparam logic [KeyW-1:0] DepthMax = 24'h7FFFFF;
  localparam logic [KeyW-1:0] DepthMin = 24'h800000;
  localparam logic [KeyW-1:0] DepthOne = 24'h000100;
  localparam logic [KeyW-1:0] DepthNeg = 24'hFFFFFF;

  typedef enum int unsigned {
    DepthSpread,
    DepthCoarse,
    DepthEdges
  } depth_style_e;

  typedef struct packed {
    logic [IdW-1:0]         face_id;
    logic                   figure;
    logic                   shadowed;
    logic signed [KeyW-1:0] z0;
    logic signed [KeyW-1:0] z1;
    logic signed [KeyW-1:0] z2;
    logic signed [KeyW-1:0] z3;
    logic                   batch_end;
    int unsigned            gap;
  } face_req_t;

  typedef struct packed {
    entry_t face;
    logic   last;
  } sorted_face_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [103:0] s_axis_tdata_i = '0;
  logic         s_axis_tuser_i = 1'b0;
  logic         s_axis_tlast_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [31:0]  m_axis_tdata_o;
  logic         m_axis_tuser_o;
  logic         m_axis_tlast_o;

  face_req_t    face_req_q[$];
  face_req_t    cur_face = '0;
  entry_t       open_batch[$];
  sorted_face_t paint_order_q[$];

  int unsigned wait_cnt = 0;
  int unsigned rx_wait = 0;
  logic        long_hold_done = 1'b0;
  int unsigned stall_cycles = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned faces_total = 0;
  int unsigned faces_accepted = 0;
  int unsigned faces_dropped = 0;
  int unsigned batches_done = 0;
  int unsigned largest_batch = 0;

  face_depth_sorter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [KeyW-1:0] pick_depth(input depth_style_e style);
    logic [31:0] r;
    int          t;
    r = $urandom();
    t = ($urandom_range(0, 6) - 3) * 256;
    case (style)
      DepthSpread: begin
        return r[KeyW-1:0];
      end
      DepthCoarse: begin
        return ($urandom_range(0, 4) == 0) ? r[KeyW-1:0] : t[KeyW-1:0];
      end
      default: begin
        case ($urandom_range(0, 4))
          0: return DepthMax;
          1: return DepthMin;
          2: return '0;
          3: return DepthNeg;
          default: return r[KeyW-1:0];
        endcase
      end
    endcase
  endfunction

  function automatic face_req_t make_face(input depth_style_e style, input logic last,
                                          input int unsigned gap);
    face_req_t f;
    f.face_id   = IdW'($urandom_range(0, 15));
    f.figure    = 1'($urandom_range(0, 1));
    f.shadowed  = 1'($urandom_range(0, 1));
    f.z0        = pick_depth(style);
    f.z1        = pick_depth(style);
    f.z2        = pick_depth(style);
    f.z3        = pick_depth(style);
    f.batch_end = last;
    f.gap       = gap;
    return f;
  endfunction

  function automatic face_req_t fixed_face(
    input logic [IdW-1:0]  id,
    input logic            fig,
    input logic            shadow,
    input logic [KeyW-1:0] z0,
    input logic [KeyW-1:0] z1,
    input logic [KeyW-1:0] z2,
    input logic [KeyW-1:0] z3,
    input logic            last
  );
    face_req_t f;
    f.face_id   = id;
    f.figure    = fig;
    f.shadowed  = shadow;
    f.z0        = z0;
    f.z1        = z1;
    f.z2        = z2;
    f.z3        = z3;
    f.batch_end = last;
    f.gap       = 0;
    return f;
  endfunction

  task automatic enqueue_face(input face_req_t f);
    face_req_q.insert(face_req_q.size(), f);
  endtask

  // Painter's order: lower key first, pyramid over box, later arrival first.
  function automatic logic paints_first(input int a, input int b);
    logic signed [KeyW-1:0] ka;
    logic signed [KeyW-1:0] kb;
    ka = open_batch[a].key;
    kb = open_batch[b].key;
    if (ka != kb) begin
      return ka < kb;
    end
    if (open_batch[a].figure != open_batch[b].figure) begin
      return open_batch[a].figure == FigPyramid;
    end
    return a > b;
  endfunction

  task automatic paint_order_accept(input face_req_t f);
    logic signed [KeyW-1:0] zs[4];
    logic signed [KeyW-1:0] k;
    entry_t                 ent;
    sorted_face_t           res;
    int                     remaining[$];
    int                     nv;
    int                     v;
    int                     i;
    int                     bi;
    faces_accepted++;
    if (open_batch.size() < MaxFacesDef) begin
      zs[0] = f.z0;
      zs[1] = f.z1;
      zs[2] = f.z2;
      zs[3] = f.z3;
      nv = (f.figure == FigPyramid) ? 3 : 4;
      k = zs[0];
      for (v = 1; v < nv; v++) begin
        if (zs[v] > k) begin
          k = zs[v];
        end
      end
      ent.face_id  = f.face_id;
      ent.figure   = f.figure;
      ent.shadowed = f.shadowed;
      ent.key      = k;
      open_batch.insert(open_batch.size(), ent);
    end else begin
      faces_dropped++;
    end
    if (f.batch_end) begin
      for (i = 0; i < open_batch.size(); i++) begin
        remaining.insert(remaining.size(), i);
      end
      while (remaining.size() != 0) begin
        bi = 0;
        for (i = 1; i < remaining.size(); i++) begin
          if (paints_first(remaining[i], remaining[bi])) begin
            bi = i;
          end
        end
        res.face = open_batch[remaining[bi]];
        res.last = (remaining.size() == 1);
        paint_order_q.insert(paint_order_q.size(), res);
        remaining.delete(bi);
      end
      open_batch.delete();
      batches_done++;
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR result %0d: %s got %0h expected %0h", results_seen, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic check_painted();
    sorted_face_t want;
    if (paint_order_q.size() == 0) begin
      report_mismatch("result with no face pending, data", m_axis_tdata_o, 0);
    end else begin
      want = paint_order_q.pop_front();
      if (m_axis_tdata_o[3:0] != want.face.face_id) begin
        report_mismatch("face id", m_axis_tdata_o[3:0], want.face.face_id);
      end
      if (m_axis_tdata_o[4] != want.face.shadowed) begin
        report_mismatch("shadow flag", m_axis_tdata_o[4], want.face.shadowed);
      end
      if (m_axis_tdata_o[28:5] != want.face.key) begin
        report_mismatch("depth key", m_axis_tdata_o[28:5], want.face.key);
      end
      if (m_axis_tuser_o != want.face.figure) begin
        report_mismatch("figure", m_axis_tuser_o, want.face.figure);
      end
      if (m_axis_tlast_o != want.last) begin
        report_mismatch("last flag", m_axis_tlast_o, want.last);
      end
    end
  endtask

  // Face request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      wait_cnt <= 0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (s_axis_tvalid_i) begin
        paint_order_accept(cur_face);
      end
      if (face_req_q.size() != 0 && wait_cnt >= face_req_q[0].gap) begin
        cur_face <= face_req_q[0];
        s_axis_tdata_i <= {3'b000, face_req_q[0].z3, face_req_q[0].z2, face_req_q[0].z1,
                           face_req_q[0].z0, face_req_q[0].shadowed, face_req_q[0].face_id};
        s_axis_tuser_i <= face_req_q[0].figure;
        s_axis_tlast_i <= face_req_q[0].batch_end;
        s_axis_tvalid_i <= 1'b1;
        wait_cnt <= 0;
        face_req_q.delete(0);
      end else begin
        s_axis_tvalid_i <= 1'b0;
        if (face_req_q.size() != 0) begin
          wait_cnt <= wait_cnt + 1;
        end
      end
    end
  end

  // Result receiver: random stalls, calm stretches and one long hold.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      rx_wait <= 0;
      long_hold_done <= 1'b0;
    end else if (!long_hold_done && results_seen >= 40) begin
      m_axis_tready_i <= 1'b0;
      rx_wait <= LongHold;
      long_hold_done <= 1'b1;
    end else if (rx_wait != 0) begin
      m_axis_tready_i <= 1'b0;
      rx_wait <= rx_wait - 1;
    end else if (results_seen % 64 < 20) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      rx_wait <= idle_len();
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      results_seen <= 0;
    end else if (m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen <= results_seen + 1;
      check_painted();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WatchdogLimit) begin
        $display("watchdog: no request moved for %0d cycles", stall_cycles);
        $display("face_depth_sorter verification failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned  n;
    int unsigned  i;
    int unsigned  r;
    logic         calm;
    depth_style_e style;

    enqueue_face(fixed_face(4'd0, FigBox, 1'b1, '0, DepthOne, DepthNeg, DepthMax, 1'b1));

    enqueue_face(fixed_face(4'd15, FigPyramid, 1'b0, DepthMin, DepthMin, DepthMin,
                            DepthMax, 1'b0));
    enqueue_face(fixed_face(4'd1, FigBox, 1'b1, DepthMin, DepthMin, DepthMin,
                            DepthMin, 1'b0));
    enqueue_face(fixed_face(4'd2, FigBox, 1'b0, DepthMin, DepthOne, '0, DepthNeg,
                            1'b0));
    enqueue_face(fixed_face(4'd3, FigBox, 1'b1, '0, DepthNeg, DepthOne, DepthMin,
                            1'b0));
    enqueue_face(fixed_face(4'd4, FigPyramid, 1'b0, DepthOne, '0, DepthMin, DepthMax,
                            1'b0));
    enqueue_face(fixed_face(4'd5, FigPyramid, 1'b1, DepthNeg, '0, DepthOne, DepthMin,
                            1'b0));
    enqueue_face(fixed_face(4'd6, FigBox, 1'b0, DepthNeg, DepthMin, DepthMin,
                            DepthMin, 1'b0));
    enqueue_face(fixed_face(4'd7, FigPyramid, 1'b1, '0, DepthMin, DepthNeg, DepthMax,
                            1'b1));

    // overflow the store; the closing face itself is dropped
    for (i = 0; i < MaxFacesDef + 1; i++) begin
      enqueue_face(make_face(DepthCoarse, i == MaxFacesDef, 0));
    end

    while (face_req_q.size() < FaceTarget) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        n = $urandom_range(1, 8);
      end else if (r < 92) begin
        n = $urandom_range(9, 16);
      end else begin
        n = $urandom_range(17, 20);
      end
      style = depth_style_e'($urandom_range(0, 2));
      calm = ($urandom_range(0, 3) == 0);
      for (i = 0; i < n; i++) begin
        enqueue_face(make_face(style, i == n - 1, calm ? 0 : idle_len()));
      end
      if (n > largest_batch) begin
        largest_batch = n;
      end
    end
    faces_total = face_req_q.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (faces_accepted < faces_total) @(posedge clk_i);
    while (paint_order_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("run covered %0d faces in %0d batches, %0d dropped on a full store",
             faces_accepted, batches_done, faces_dropped);
    $display("checked %0d sorted faces; largest random batch %0d, receiver held %0d cycles",
             results_seen, largest_batch, LongHold);
    if (mismatch_cnt == 0 && paint_order_q.size() == 0 && open_batch.size() == 0) begin
      $display("face_depth_sorter verification clean");
    end else begin
      $display("face_depth_sorter verification failed");
    end
    $finish;
  end

endmodule
